/* src/qvr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared types and constants for the quaternion vector rotate unit.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int unsigned QVR_FIFO_DEPTH = 4;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned PROD_W  = 2 * DATA_W;        // q part times q part
    localparam int unsigned MTX_W   = PROD_W + 2;        // matrix term, |P| <= 2^32
    localparam int unsigned MV_W    = MTX_W + DATA_W;    // matrix term times vector part
    localparam int unsigned ACC_W   = MV_W + 1;          // sum of three
    localparam int unsigned FRAC_W  = 30;
    localparam int unsigned RND_W   = ACC_W - FRAC_W;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'd1 << (FRAC_W - 1));
    localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [DATA_W-1:0] quat_w;
        logic signed [DATA_W-1:0] quat_x;
        logic signed [DATA_W-1:0] quat_y;
        logic signed [DATA_W-1:0] quat_z;
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] vec_z;
    } qvr_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic                     saturated;
    } qvr_rsp_t;

    // matrix terms and the vector, handed from front to back
    typedef struct packed {
        logic signed [MTX_W-1:0]  m00;
        logic signed [MTX_W-1:0]  m01;
        logic signed [MTX_W-1:0]  m02;
        logic signed [MTX_W-1:0]  m10;
        logic signed [MTX_W-1:0]  m11;
        logic signed [MTX_W-1:0]  m12;
        logic signed [MTX_W-1:0]  m20;
        logic signed [MTX_W-1:0]  m21;
        logic signed [MTX_W-1:0]  m22;
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] vec_z;
    } qvr_job_t;

endpackage

/* src/qvr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_front
// Takes requests, forms the ten quaternion products, then the nine matrix terms.
// ----------------------------------------------------------------------------
module qvr_front
    import qvr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  qvr_req_t req_data,
    output logic     job_valid,
    input  logic     job_ready,
    output qvr_job_t job_data
);

    logic                     s1_valid_reg;
    logic                     s2_valid_reg;
    logic                     adv;
    logic signed [PROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic signed [DATA_W-1:0] vx_reg, vy_reg, vz_reg;
    qvr_job_t                 job_reg;
    qvr_job_t                 job_next;

    // the whole front stalls only when its last stage cannot hand off
    assign adv       = !s2_valid_reg || job_ready;
    assign req_ready = adv;
    assign job_valid = s2_valid_reg;
    assign job_data  = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= req_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ww_reg <= req_data.quat_w * req_data.quat_w;
            xx_reg <= req_data.quat_x * req_data.quat_x;
            yy_reg <= req_data.quat_y * req_data.quat_y;
            zz_reg <= req_data.quat_z * req_data.quat_z;
            xy_reg <= req_data.quat_x * req_data.quat_y;
            wz_reg <= req_data.quat_w * req_data.quat_z;
            xz_reg <= req_data.quat_x * req_data.quat_z;
            wy_reg <= req_data.quat_w * req_data.quat_y;
            yz_reg <= req_data.quat_y * req_data.quat_z;
            wx_reg <= req_data.quat_w * req_data.quat_x;
            vx_reg <= req_data.vec_x;
            vy_reg <= req_data.vec_y;
            vz_reg <= req_data.vec_z;
            job_reg <= job_next;
        end
    end

    // diagonal terms from squares, off-diagonal from doubled products
    always_comb
    begin
        job_next.m00 = MTX_W'(ww_reg) + MTX_W'(xx_reg) - MTX_W'(yy_reg) - MTX_W'(zz_reg);
        job_next.m11 = MTX_W'(ww_reg) - MTX_W'(xx_reg) + MTX_W'(yy_reg) - MTX_W'(zz_reg);
        job_next.m22 = MTX_W'(ww_reg) - MTX_W'(xx_reg) - MTX_W'(yy_reg) + MTX_W'(zz_reg);
        job_next.m01 = (MTX_W'(xy_reg) - MTX_W'(wz_reg)) <<< 1;
        job_next.m10 = (MTX_W'(xy_reg) + MTX_W'(wz_reg)) <<< 1;
        job_next.m02 = (MTX_W'(xz_reg) + MTX_W'(wy_reg)) <<< 1;
        job_next.m20 = (MTX_W'(xz_reg) - MTX_W'(wy_reg)) <<< 1;
        job_next.m12 = (MTX_W'(yz_reg) - MTX_W'(wx_reg)) <<< 1;
        job_next.m21 = (MTX_W'(yz_reg) + MTX_W'(wx_reg)) <<< 1;
        job_next.vec_x = vx_reg;
        job_next.vec_y = vy_reg;
        job_next.vec_z = vz_reg;
    end

endmodule

/* src/qvr_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_fifo
// Short queue of matrix jobs between the front and the back.
// ----------------------------------------------------------------------------
module qvr_fifo
    import qvr_pkg::*;
#(
    parameter int unsigned DEPTH = QVR_FIFO_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  qvr_job_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output qvr_job_t pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    qvr_job_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/qvr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_back
// Matrix times vector, row sums, rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module qvr_back
    import qvr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_ready,
    input  qvr_job_t job_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output qvr_rsp_t rsp_data
);

    logic                    b1_valid_reg;
    logic                    b2_valid_reg;
    logic                    out_valid_reg;
    logic                    adv;
    logic signed [MV_W-1:0]  p00_reg, p01_reg, p02_reg;
    logic signed [MV_W-1:0]  p10_reg, p11_reg, p12_reg;
    logic signed [MV_W-1:0]  p20_reg, p21_reg, p22_reg;
    logic signed [ACC_W-1:0] acc_x_reg, acc_y_reg, acc_z_reg;
    logic signed [RND_W-1:0] rnd_x, rnd_y, rnd_z;
    logic                    clip_x, clip_y, clip_z;
    qvr_rsp_t                rsp_reg, rsp_next;

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [RND_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > RND_W'(SAT_MAX))
            r = SAT_MAX;
        else if (v < RND_W'(SAT_MIN))
            r = SAT_MIN;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    assign adv       = !out_valid_reg || rsp_ready;
    assign job_ready = adv;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= job_valid;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p00_reg <= job_data.m00 * job_data.vec_x;
            p01_reg <= job_data.m01 * job_data.vec_y;
            p02_reg <= job_data.m02 * job_data.vec_z;
            p10_reg <= job_data.m10 * job_data.vec_x;
            p11_reg <= job_data.m11 * job_data.vec_y;
            p12_reg <= job_data.m12 * job_data.vec_z;
            p20_reg <= job_data.m20 * job_data.vec_x;
            p21_reg <= job_data.m21 * job_data.vec_y;
            p22_reg <= job_data.m22 * job_data.vec_z;
            // half an lsb added here so the next stage only shifts
            acc_x_reg <= ACC_W'(p00_reg) + ACC_W'(p01_reg) + ACC_W'(p02_reg) + RND_HALF;
            acc_y_reg <= ACC_W'(p10_reg) + ACC_W'(p11_reg) + ACC_W'(p12_reg) + RND_HALF;
            acc_z_reg <= ACC_W'(p20_reg) + ACC_W'(p21_reg) + ACC_W'(p22_reg) + RND_HALF;
            rsp_reg <= rsp_next;
        end
    end

    // arithmetic shift is a floor, so ties go toward plus infinity
    assign rnd_x = acc_x_reg[ACC_W-1:FRAC_W];
    assign rnd_y = acc_y_reg[ACC_W-1:FRAC_W];
    assign rnd_z = acc_z_reg[ACC_W-1:FRAC_W];

    assign clip_x = (rnd_x > RND_W'(SAT_MAX)) || (rnd_x < RND_W'(SAT_MIN));
    assign clip_y = (rnd_y > RND_W'(SAT_MAX)) || (rnd_y < RND_W'(SAT_MIN));
    assign clip_z = (rnd_z > RND_W'(SAT_MAX)) || (rnd_z < RND_W'(SAT_MIN));

    always_comb
    begin
        rsp_next.out_x     = sat16(rnd_x);
        rsp_next.out_y     = sat16(rnd_y);
        rsp_next.out_z     = sat16(rnd_z);
        rsp_next.saturated = clip_x || clip_y || clip_z;
    end

endmodule

/* src/quaternion_vector_rotate_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit
// Rotates a 16-bit vector by a Q1.15 quaternion through its rotation matrix.
// ----------------------------------------------------------------------------
// Takes one request per cycle while req_ready is high and returns one
// response per request, in order. The front forms the ten quaternion
// products and the nine non-normalized matrix terms in two register stages;
// a FIFO_DEPTH-entry queue then feeds the back, which multiplies by the
// vector, sums each row, rounds to nearest (ties up) and saturates in three
// stages. Throughput is one item per cycle while neither side stalls; the
// queue lets req_ready stay high while rsp_ready is low until it fills.
// saturated is set when any component was clipped. The quaternion is not
// normalized, so the result scales with |q|^2.
module quaternion_vector_rotate_unit
    import qvr_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = QVR_FIFO_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  qvr_req_t req_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output qvr_rsp_t rsp_data
);

    logic     fj_valid, fj_ready;
    qvr_job_t fj_data;
    logic     bj_valid, bj_ready;
    qvr_job_t bj_data;

    qvr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job_data  (fj_data)
    );

    qvr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fj_valid),
        .push_ready (fj_ready),
        .push_data  (fj_data),
        .pop_valid  (bj_valid),
        .pop_ready  (bj_ready),
        .pop_data   (bj_data)
    );

    qvr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job_data  (bj_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

/* src/qvr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_checker
// Port-level checks for the quaternion vector rotate unit, bound to the top.
// ----------------------------------------------------------------------------
module qvr_checker
    import qvr_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_ready,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input qvr_rsp_t rsp_data
);

    // a stalled response keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    // nothing comes out in the cycle after reset is released
    a_rsp_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !rsp_valid)
        else $error("response valid right after reset");

    // a clipped response carries at least one full-scale component
    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.saturated |->
            rsp_data.out_x == SAT_MAX || rsp_data.out_x == SAT_MIN ||
            rsp_data.out_y == SAT_MAX || rsp_data.out_y == SAT_MIN ||
            rsp_data.out_z == SAT_MAX || rsp_data.out_z == SAT_MIN)
        else $error("saturated set without a full-scale component");

    // the unit has nothing in flight right after reset is released, so it takes requests
    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> req_ready)
        else $error("request not taken right after reset");

endmodule

bind quaternion_vector_rotate_unit qvr_checker u_qvr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quaternion vector rotate unit.
// ----------------------------------------------------------------------------
// A short table of rotation requests comes first. Rows with an obvious answer
// carry a typed response, and the rest go through the rotation predictor.
// Random requests follow: half of them unit quaternions with random vectors,
// the rest full-range noise, edge values and small values. Both handshakes idle at
// random. One long receiver hold-off fills the block, and one sender pause
// lets the block drain completely. Responses are checked in order, field by
// field.
// ----------------------------------------------------------------------------
module tb;
    import qvr_pkg::*;

    localparam int  RANDOM_ITEMS = 1830;
    localparam int  LONG_HOLD    = 300;
    localparam int  DRAIN_CYCLES = 20;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_W - 1);

    typedef struct {
        qvr_req_t req;
        bit       typed;
        qvr_rsp_t want;
    } stim_row_t;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    qvr_req_t req_data;
    logic     rsp_valid;
    logic     rsp_ready;
    qvr_rsp_t rsp_data;

    qvr_rsp_t  rotated_q[$];
    qvr_rsp_t  pending_rotation;
    qvr_rsp_t  oldest_rotation;
    stim_row_t directed_rows[$];
    int        errors;
    int        cycle_count;
    bit        calm_tx;
    bit        calm_rx;
    bit        hold_rx;
    int        burst_left;

    quaternion_vector_rotate_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // non-normalized rotation matrix times vector, exact in 64 bits
    function automatic qvr_rsp_t rotate_vector(qvr_req_t r);
        longint   w, x, y, z;
        longint   v[3];
        longint   m[9];
        longint   acc;
        longint   q;
        longint   res[3];
        bit       clip;
        qvr_rsp_t rsp;
        w = r.quat_w;
        x = r.quat_x;
        y = r.quat_y;
        z = r.quat_z;
        v[0] = r.vec_x;
        v[1] = r.vec_y;
        v[2] = r.vec_z;
        m[0] = w * w + x * x - y * y - z * z;
        m[1] = 2 * (x * y - w * z);
        m[2] = 2 * (x * z + w * y);
        m[3] = 2 * (x * y + w * z);
        m[4] = w * w - x * x + y * y - z * z;
        m[5] = 2 * (y * z - w * x);
        m[6] = 2 * (x * z - w * y);
        m[7] = 2 * (y * z + w * x);
        m[8] = w * w - x * x - y * y + z * z;
        clip = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc = m[3*i] * v[0] + m[3*i+1] * v[1] + m[3*i+2] * v[2];
            // arithmetic shift gives floor, so ties go up
            q = (acc + ROUND_HALF) >>> FRAC_W;
            if (q > 32767)
            begin
                q = 32767;
                clip = 1'b1;
            end
            else if (q < -32768)
            begin
                q = -32768;
                clip = 1'b1;
            end
            res[i] = q;
        end
        rsp.out_x     = 16'(res[0]);
        rsp.out_y     = 16'(res[1]);
        rsp.out_z     = 16'(res[2]);
        rsp.saturated = clip;
        return rsp;
    endfunction

    function automatic void add_row(
        int w, int x, int y, int z,
        int vx, int vy, int vz,
        int typed,
        int ox, int oy, int oz,
        int sat);
        stim_row_t row;
        row.req.quat_w     = 16'(w);
        row.req.quat_x     = 16'(x);
        row.req.quat_y     = 16'(y);
        row.req.quat_z     = 16'(z);
        row.req.vec_x      = 16'(vx);
        row.req.vec_y      = 16'(vy);
        row.req.vec_z      = 16'(vz);
        row.typed          = (typed != 0);
        row.want.out_x     = 16'(ox);
        row.want.out_y     = 16'(oy);
        row.want.out_z     = 16'(oz);
        row.want.saturated = (sat != 0);
        directed_rows.push_back(row);
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm_tx || burst_left > 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 96)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [15:0] pick_edge();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return 16'sd1;
            4: return -16'sd1;
            default: return 16'sd16384;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_vec_part();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 16'($urandom);
        else if (r < 9)
            return 16'($signed($urandom_range(0, 2000)) - 1000);
        else
            return pick_edge();
    endfunction

    // random unit quaternion, scaled to full Q1.15
    function automatic qvr_req_t make_rotation();
        real      a, b, c, d, n, scale;
        qvr_req_t r;
        a = real'($urandom_range(0, 65534)) - 32767.0;
        b = real'($urandom_range(0, 65534)) - 32767.0;
        c = real'($urandom_range(0, 65534)) - 32767.0;
        d = real'($urandom_range(0, 65534)) - 32767.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
        begin
            a = 1.0;
            n = 1.0;
        end
        scale = 32767.0 / n;
        r.quat_w = 16'($rtoi(a * scale));
        r.quat_x = 16'($rtoi(b * scale));
        r.quat_y = 16'($rtoi(c * scale));
        r.quat_z = 16'($rtoi(d * scale));
        r.vec_x  = pick_vec_part();
        r.vec_y  = pick_vec_part();
        r.vec_z  = pick_vec_part();
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_rotation(input qvr_req_t req, input qvr_rsp_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_data         = req;
        pending_rotation = want;
        req_valid        = 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    // response checking and expectation capture, both on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (rotated_q.size() == 0)
                begin
                    $display("%0t: unexpected response, got %p", $time, rsp_data);
                    errors++;
                end
                else
                begin
                    oldest_rotation = rotated_q.pop_front();
                    if (rsp_data.out_x !== oldest_rotation.out_x)
                    begin
                        $display("%0t: out_x mismatch, expected %0d, got %0d",
                                 $time, oldest_rotation.out_x, rsp_data.out_x);
                        errors++;
                    end
                    if (rsp_data.out_y !== oldest_rotation.out_y)
                    begin
                        $display("%0t: out_y mismatch, expected %0d, got %0d",
                                 $time, oldest_rotation.out_y, rsp_data.out_y);
                        errors++;
                    end
                    if (rsp_data.out_z !== oldest_rotation.out_z)
                    begin
                        $display("%0t: out_z mismatch, expected %0d, got %0d",
                                 $time, oldest_rotation.out_z, rsp_data.out_z);
                        errors++;
                    end
                    if (rsp_data.saturated !== oldest_rotation.saturated)
                    begin
                        $display("%0t: saturated mismatch, expected %0b, got %0b",
                                 $time, oldest_rotation.saturated, rsp_data.saturated);
                        errors++;
                    end
                end
            end
            if (req_valid && req_ready)
                rotated_q.push_back(pending_rotation);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // response side backpressure
    initial
    begin
        int stall_left;
        int r;
        stall_left = 0;
        rsp_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_ready = 1'b0;
                stall_left--;
            end
            else if (hold_rx)
            begin
                hold_rx    = 1'b0;
                stall_left = LONG_HOLD - 1;
                rsp_ready  = 1'b0;
            end
            else if (calm_rx)
                rsp_ready = 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    rsp_ready = 1'b1;
                else if (r < 97)
                begin
                    rsp_ready  = 1'b0;
                    stall_left = $urandom_range(0, 3);
                end
                else
                begin
                    rsp_ready  = 1'b0;
                    stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    initial
    begin
        qvr_req_t req;
        qvr_rsp_t want;
        int       kind;
        errors      = 0;
        cycle_count = 0;
        calm_tx     = 1'b0;
        calm_rx     = 1'b0;
        hold_rx     = 1'b0;
        burst_left  = 0;
        req_valid   = 1'b0;
        req_data    = '0;
        pending_rotation = '0;
        rst_n       = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // zero quaternion wipes the vector
        add_row(0, 0, 0, 0, 32767, -32768, 1, 1, 0, 0, 0, 0);
        // w of full-scale negative is exactly one, so R is the identity
        add_row(-32768, 0, 0, 0, 32767, -32768, 12345, 1, 32767, -32768, 12345, 0);
        add_row(-32768, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        // all parts full-scale negative: permutes the vector times four
        add_row(-32768, -32768, -32768, -32768, 1, 2, 3, 1, 12, 4, 8, 0);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 1,
                -32768, -32768, -32768, 1);
        add_row(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 1,
                32767, 32767, 32767, 1);
        // quarter scale, halfway values round up
        add_row(16384, 0, 0, 0, 2, -2, -6, 1, 1, 0, -1, 0);
        add_row(16384, 0, 0, 0, -2, 6, -32768, 1, 0, 2, -8192, 0);
        // half turns about each axis
        add_row(0, -32768, 0, 0, 100, 200, -300, 1, 100, -200, 300, 0);
        add_row(0, -32768, 0, 0, -32768, -32768, 5, 1, -32768, 32767, -5, 1);
        add_row(0, 0, -32768, 0, 7, -7, 32767, 1, -7, -7, -32767, 0);
        add_row(0, 0, 0, -32768, 1, -32768, 0, 1, -1, 32767, 0, 1);
        // the rest go through the predictor
        add_row(32767, 0, 0, 0, 32767, -32768, 1, 0, 0, 0, 0, 0);
        add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0);
        add_row(32767, 32767, 32767, 32767, -32768, 1000, -1, 0, 0, 0, 0, 0);
        add_row(23170, 0, 0, 23170, 1000, 2000, 3000, 0, 0, 0, 0, 0);
        add_row(23170, 23170, 0, 0, -5000, 12000, 32767, 0, 0, 0, 0, 0);
        add_row(23170, 0, -23170, 0, 32767, 0, -32768, 0, 0, 0, 0, 0);
        add_row(32767, -32768, 32767, -32768, -32768, 32767, -32768, 0, 0, 0, 0, 0);
        add_row(-1, 1, -1, 1, 32767, 32767, 32767, 0, 0, 0, 0, 0);
        add_row(16384, 16384, 16384, 16384, 3, -3, 1, 0, 0, 0, 0, 0);
        add_row(-12345, 6789, -20000, 14000, -12000, 30000, -25000, 0, 0, 0, 0, 0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].typed)
                want = directed_rows[i].want;
            else
                want = rotate_vector(directed_rows[i].req);
            send_rotation(directed_rows[i].req, want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm_tx = ((n % 400) >= 100) && ((n % 400) < 160);
            calm_rx = calm_tx;
            if (n == 600)
            begin
                // receiver stalls while the sender keeps offering
                hold_rx    = 1'b1;
                burst_left = 40;
            end
            if (n == 1200)
            begin
                req_valid = 1'b0;
                while (rotated_q.size() != 0)
                    @(negedge clk);
                @(negedge clk);
            end
            kind = $urandom_range(0, 99);
            if (kind < 50)
                req = make_rotation();
            else if (kind < 75)
            begin
                req.quat_w = 16'($urandom);
                req.quat_x = 16'($urandom);
                req.quat_y = 16'($urandom);
                req.quat_z = 16'($urandom);
                req.vec_x  = 16'($urandom);
                req.vec_y  = 16'($urandom);
                req.vec_z  = 16'($urandom);
            end
            else if (kind < 90)
            begin
                req.quat_w = pick_edge();
                req.quat_x = pick_edge();
                req.quat_y = pick_edge();
                req.quat_z = pick_edge();
                req.vec_x  = pick_edge();
                req.vec_y  = pick_edge();
                req.vec_z  = pick_edge();
            end
            else
            begin
                req.quat_w = 16'($signed($urandom_range(0, 64)) - 32);
                req.quat_x = 16'($signed($urandom_range(0, 64)) - 32);
                req.quat_y = 16'($signed($urandom_range(0, 64)) - 32);
                req.quat_z = 16'($signed($urandom_range(0, 64)) - 32);
                req.vec_x  = pick_vec_part();
                req.vec_y  = pick_vec_part();
                req.vec_z  = pick_vec_part();
            end
            send_rotation(req, rotate_vector(req));
            if (burst_left > 0)
                burst_left--;
        end
        req_valid = 1'b0;
        calm_tx   = 1'b0;
        calm_rx   = 1'b0;

        while (rotated_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0 && rotated_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
src/qvr_pkg.sv
src/qvr_front.sv
src/qvr_fifo.sv
src/qvr_back.sv
src/quaternion_vector_rotate_unit.sv
src/qvr_checker.sv
dv/tb.sv
